/* hw/rtl/pfr_pkg.sv */
// ----------------------------------------------------------------------------
// pfr_pkg
// Shared types and constants for the parity-checked byte frame receiver.
// ----------------------------------------------------------------------------
package pfr_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned IdW     = 6;

  localparam logic [ByteW-1:0] GarbageReset = 8'h00;

  typedef enum logic [1:0] {
    PH_FIRST   = 2'd0,
    PH_CONTROL = 2'd1,
    PH_LENGTH  = 2'd2,
    PH_PAYLOAD = 2'd3
  } phase_t;

  typedef struct packed {
    logic             payload_valid;
    logic [ByteW-1:0] payload_byte;
    logic             frame_done;
    logic             frame_ok;
    logic [IdW-1:0]   message_id;
    logic [ByteW-1:0] frame_length;
  } result_t;

  typedef struct packed {
    logic has_result;
    logic advance;
  } flow_t;

endpackage

/* hw/rtl/pfr_in_stage.sv */
// ----------------------------------------------------------------------------
// pfr_in_stage
// Input register: holds one received byte until the deframer takes it.
// ----------------------------------------------------------------------------
module pfr_in_stage
  import pfr_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [ByteW-1:0] rx_byte,
  input  logic             advance,
  output logic             item_valid,
  output logic [ByteW-1:0] item_byte
);

  logic             held;
  logic [ByteW-1:0] held_byte;

  assign in_ready   = !held || advance;
  assign item_valid = held;
  assign item_byte  = held_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_byte <= rx_byte;
    end
  end

endmodule

/* hw/rtl/pfr_deframe.sv */
// ----------------------------------------------------------------------------
// pfr_deframe
// Frame phase tracking, parity accumulation and end-of-frame verdict.
// ----------------------------------------------------------------------------
module pfr_deframe
  import pfr_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [ByteW-1:0] cfg_data,
  input  logic             item_valid,
  input  logic [ByteW-1:0] item_byte,
  input  logic             slot_free,
  output flow_t            flow,
  output result_t          result
);

  phase_t           phase, phase_next;
  logic [ByteW-1:0] garbage;
  logic [ByteW-1:0] control_reg, control_next;
  logic [ByteW-1:0] length_reg, length_next;
  logic [ByteW-1:0] remaining, remaining_next;
  logic             payload_parity, parity_next;
  logic             done;
  logic             byte_par;

  assign byte_par = ^item_byte;

  // next state
  always_comb begin
    phase_next     = phase;
    control_next   = control_reg;
    length_next    = length_reg;
    remaining_next = remaining;
    parity_next    = payload_parity;
    done           = 1'b0;
    unique case (phase)
      PH_FIRST, PH_CONTROL: begin
        if (phase == PH_FIRST && item_byte == garbage) begin
          phase_next = PH_CONTROL;
        end else begin
          control_next = item_byte;
          parity_next  = 1'b0;
          if (item_byte[7]) begin
            phase_next = PH_LENGTH;
          end else begin
            length_next    = '0;
            remaining_next = ByteW'(1);
            phase_next     = PH_PAYLOAD;
          end
        end
      end
      PH_LENGTH: begin
        length_next    = item_byte;
        parity_next    = byte_par;
        remaining_next = item_byte;
        if (item_byte == '0) begin
          done       = 1'b1;
          phase_next = PH_FIRST;
        end else begin
          phase_next = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        parity_next    = payload_parity ^ byte_par;
        remaining_next = remaining - ByteW'(1);
        if (remaining_next == '0) begin
          done       = 1'b1;
          phase_next = PH_FIRST;
        end
      end
      default: phase_next = PH_FIRST;
    endcase
  end

  // outputs
  always_comb begin
    result = '0;
    flow.has_result = 1'b0;
    unique case (phase)
      PH_LENGTH: begin
        flow.has_result = done;
      end
      PH_PAYLOAD: begin
        flow.has_result      = 1'b1;
        result.payload_valid = 1'b1;
        result.payload_byte  = item_byte;
      end
      default: flow.has_result = 1'b0;
    endcase
    if (done) begin
      result.frame_done   = 1'b1;
      result.frame_ok     = (control_reg[0] == ^control_reg[7:1]) &&
                            (control_reg[1] == parity_next);
      result.message_id   = control_reg[ByteW-1:2];
      result.frame_length = length_next;
    end
    flow.advance = item_valid && (!flow.has_result || slot_free);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      garbage <= GarbageReset;
    end else if (cfg_write) begin
      garbage <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_FIRST;
      control_reg    <= '0;
      length_reg     <= '0;
      remaining      <= '0;
      payload_parity <= 1'b0;
    end else if (flow.advance) begin
      phase          <= phase_next;
      control_reg    <= control_next;
      length_reg     <= length_next;
      remaining      <= remaining_next;
      payload_parity <= parity_next;
    end
  end

endmodule

/* hw/rtl/pfr_out_stage.sv */
// ----------------------------------------------------------------------------
// pfr_out_stage
// Result register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module pfr_out_stage
  import pfr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t result_in,
  output logic    slot_free,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t result_out
);

  logic    full;
  result_t held;

  assign slot_free  = !full || out_ready;
  assign out_valid  = full;
  assign result_out = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load) begin
      full <= 1'b1;
    end else if (out_ready) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result_in;
    end
  end

endmodule

/* hw/rtl/parity_frame_receiver_core.sv */
// ----------------------------------------------------------------------------
// parity_frame_receiver_core
// Splits a received byte stream into parity-checked frames.
// ----------------------------------------------------------------------------
// Input channel: one link byte per request on in_valid/in_ready/rx_byte.
// Output channel: zero or one result per byte on out_valid/out_ready.
//   Payload bytes appear with payload_valid set; the result ending a frame
//   carries frame_done, frame_ok, message_id and frame_length.
// cfg_write/cfg_data set the garbage byte value skipped at frame start.
// Path: each byte is held in the input register, and its result is offered
//   from the result register.
// Throughput: one byte per cycle unless a result waits for out_ready; the
//   phase update and parity XOR sit in a single logic stage between the
//   input and result registers.
// Reset: frame state returns to waiting for the first byte, garbage value 0,
//   both registers empty.
// Stall: while out_ready is low the held result stays; a byte giving no
//   result still passes, and one giving a result waits in the input
//   register, after which in_ready drops.
// ----------------------------------------------------------------------------
module parity_frame_receiver_core
  import pfr_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [ByteW-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [ByteW-1:0] rx_byte,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             payload_valid,
  output logic [ByteW-1:0] payload_byte,
  output logic             frame_done,
  output logic             frame_ok,
  output logic [IdW-1:0]   message_id,
  output logic [ByteW-1:0] frame_length
);

  logic             item_valid;
  logic [ByteW-1:0] item_byte;
  logic             slot_free;
  flow_t            flow;
  result_t          result, result_q;

  pfr_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .advance    (flow.advance),
    .item_valid (item_valid),
    .item_byte  (item_byte)
  );

  pfr_deframe u_deframe (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item_byte  (item_byte),
    .slot_free  (slot_free),
    .flow       (flow),
    .result     (result)
  );

  pfr_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (flow.advance && flow.has_result),
    .result_in  (result),
    .slot_free  (slot_free),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .result_out (result_q)
  );

  assign payload_valid = result_q.payload_valid;
  assign payload_byte  = result_q.payload_byte;
  assign frame_done    = result_q.frame_done;
  assign frame_ok      = result_q.frame_ok;
  assign message_id    = result_q.message_id;
  assign frame_length  = result_q.frame_length;

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for parity_frame_receiver_core.
// A short table of hand-made frames (garbage skip, zero-length, extreme and
// bad-parity frames), then random frames and noise under three settings of
// the garbage byte and of source/sink idling, with one long sink stall.
// Every accepted byte goes through a local deframer; its results (the table's
// own for typed rows) are compared field by field with what the block hands out.
// ----------------------------------------------------------------------------
module tb;
  import pfr_pkg::*;

  localparam int CycleLimit  = 200000;
  localparam int DrainCycles = 6;
  localparam int HoldCycles  = 300;

  typedef struct packed {
    logic [ByteW-1:0] rx;
    logic             typed;
    logic             gives;
    result_t          want;
  } dir_row_t;

  localparam result_t NoResult = '0;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             cfg_write = 1'b0;
  logic [ByteW-1:0] cfg_data  = '0;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  logic [ByteW-1:0] rx_byte   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic             payload_valid;
  logic [ByteW-1:0] payload_byte;
  logic             frame_done;
  logic             frame_ok;
  logic [IdW-1:0]   message_id;
  logic [ByteW-1:0] frame_length;

  parity_frame_receiver_core dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .payload_valid (payload_valid),
    .payload_byte  (payload_byte),
    .frame_done    (frame_done),
    .frame_ok      (frame_ok),
    .message_id    (message_id),
    .frame_length  (frame_length)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // deframer state
  logic [ByteW-1:0] skip_value = GarbageReset;
  phase_t           fr_phase   = PH_FIRST;
  logic [ByteW-1:0] fr_ctl     = '0;
  logic [ByteW-1:0] fr_len     = '0;
  logic [ByteW-1:0] fr_left    = '0;
  logic             fr_par     = 1'b0;

  result_t due_results [$];
  result_t want_r;
  int      fail_count    = 0;
  int      cycle_count   = 0;
  int      bytes_sent    = 0;
  int      send_gap_pct  = 20;
  int      recv_gap_pct  = 64;
  int      hold_requests = 0;
  int      hold_seen     = 0;
  int      hold_left     = 0;

  dir_row_t directed_rows [21] = '{
    {8'h00, 1'b1, 1'b0, NoResult},                                   // garbage skip
    {8'h00, 1'b1, 1'b0, NoResult},                                   // control equal to garbage
    {8'hFF, 1'b1, 1'b1, {1'b1, 8'hFF, 1'b1, 1'b1, 6'h00, 8'h00}},
    {8'h81, 1'b1, 1'b0, NoResult},
    {8'h00, 1'b1, 1'b1, {1'b0, 8'h00, 1'b1, 1'b1, 6'h20, 8'h00}},    // zero length
    {8'hFF, 1'b1, 1'b0, NoResult},
    {8'h01, 1'b1, 1'b0, NoResult},
    {8'h00, 1'b1, 1'b1, {1'b1, 8'h00, 1'b1, 1'b1, 6'h3F, 8'h01}},
    {8'hFC, 1'b1, 1'b0, NoResult},
    {8'h02, 1'b1, 1'b0, NoResult},
    {8'h01, 1'b0, 1'b0, NoResult},
    {8'h01, 1'b0, 1'b0, NoResult},
    {8'h03, 1'b1, 1'b0, NoResult},
    {8'h07, 1'b0, 1'b0, NoResult},
    {8'h02, 1'b1, 1'b0, NoResult},
    {8'h00, 1'b1, 1'b1, {1'b1, 8'h00, 1'b1, 1'b0, 6'h00, 8'h00}},    // bad control parity
    {8'h00, 1'b1, 1'b0, NoResult},
    {8'h80, 1'b1, 1'b0, NoResult},
    {8'h00, 1'b1, 1'b1, {1'b0, 8'h00, 1'b1, 1'b0, 6'h20, 8'h00}},
    {8'h7F, 1'b1, 1'b0, NoResult},
    {8'hAA, 1'b0, 1'b0, NoResult}
  };

  function automatic void take_control(input logic [ByteW-1:0] b);
    fr_ctl = b;
    fr_par = 1'b0;
    if (b[7]) begin
      fr_phase = PH_LENGTH;
    end else begin
      fr_len   = '0;
      fr_left  = 8'd1;
      fr_phase = PH_PAYLOAD;
    end
  endfunction

  function automatic void close_frame(inout result_t r);
    r.frame_done   = 1'b1;
    r.frame_ok     = (fr_ctl[0] == ^fr_ctl[7:1]) && (fr_ctl[1] == fr_par);
    r.message_id   = fr_ctl[7:2];
    r.frame_length = fr_len;
    fr_phase       = PH_FIRST;
  endfunction

  // returns 1 when the byte produces a result
  function automatic bit deframe_byte(input logic [ByteW-1:0] b, output result_t r);
    r = '0;
    case (fr_phase)
      PH_FIRST: begin
        if (b == skip_value) fr_phase = PH_CONTROL;
        else take_control(b);
        return 1'b0;
      end
      PH_CONTROL: begin
        take_control(b);
        return 1'b0;
      end
      PH_LENGTH: begin
        fr_len = b;
        fr_par = ^b;
        if (b == '0) begin
          fr_left = '0;
          close_frame(r);
          return 1'b1;
        end
        fr_left  = b;
        fr_phase = PH_PAYLOAD;
        return 1'b0;
      end
      default: begin
        fr_par          = fr_par ^ (^b);
        r.payload_valid = 1'b1;
        r.payload_byte  = b;
        fr_left         = fr_left - 8'd1;
        if (fr_left == '0) close_frame(r);
        return 1'b1;
      end
    endcase
  endfunction

  task automatic push_byte(input logic [ByteW-1:0] b);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_predicted(input logic [ByteW-1:0] b);
    result_t r;
    push_byte(b);
    if (deframe_byte(b, r)) due_results.push_back(r);
    bytes_sent++;
  endtask

  // well-formed frame with random content, sometimes with broken parity
  task automatic offer_frame(input int fixed_len);
    int               n;
    bit               lng;
    logic [ByteW-1:0] ctl;
    logic [ByteW-1:0] body [$];
    logic             par;
    lng = (fixed_len >= 0) || ($urandom_range(1) == 1);
    if (fixed_len >= 0) n = fixed_len;
    else if (!lng) n = 1;
    else if ($urandom_range(19) == 0) n = $urandom_range(40, 9);
    else n = $urandom_range(6);
    par = lng ? ^n[7:0] : 1'b0;
    repeat (n) begin
      body.push_back(ByteW'($urandom_range(255)));
      par = par ^ (^body[$]);
    end
    ctl      = '0;
    ctl[7]   = lng;
    ctl[6:2] = 5'($urandom_range(31));
    ctl[1]   = par;
    ctl[0]   = ^ctl[7:1];
    case ($urandom_range(9))
      0: ctl[0] = ~ctl[0];
      1: ctl[1] = ~ctl[1];
      default: ;
    endcase
    if (ctl == skip_value || $urandom_range(3) == 0) send_predicted(skip_value);
    send_predicted(ctl);
    if (lng) send_predicted(n[7:0]);
    foreach (body[i]) send_predicted(body[i]);
  endtask

  task automatic send_random(input int upto);
    while (bytes_sent < upto) begin
      if ($urandom_range(99) < 10) begin
        repeat ($urandom_range(3, 1)) send_predicted(ByteW'($urandom_range(255)));
      end else begin
        offer_frame(-1);
      end
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_garbage(input logic [ByteW-1:0] v);
    settle();
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    skip_value = v;
  endtask

  function automatic void check_field(input string name, input logic [ByteW-1:0] want,
                                      input logic [ByteW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // sink: random back-pressure, plus a long hold when one is requested
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_seen != hold_requests) begin
      hold_seen <= hold_requests;
      hold_left <= HoldCycles;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        $display("%0t: result with none due: expected nothing actual byte %0h done %0b",
                 $time, payload_byte, frame_done);
        fail_count++;
      end else begin
        want_r = due_results.pop_front();
        check_field("payload_valid", want_r.payload_valid, payload_valid);
        check_field("payload_byte", want_r.payload_byte, payload_byte);
        check_field("frame_done", want_r.frame_done, frame_done);
        check_field("frame_ok", want_r.frame_ok, frame_ok);
        check_field("message_id", want_r.message_id, message_id);
        check_field("frame_length", want_r.frame_length, frame_length);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  initial begin
    result_t r;
    bit      has;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // hand-made frames, garbage byte at its reset value
    foreach (directed_rows[i]) begin
      push_byte(directed_rows[i].rx);
      has = deframe_byte(directed_rows[i].rx, r);
      if (directed_rows[i].typed) begin
        if (directed_rows[i].gives) due_results.push_back(directed_rows[i].want);
      end else if (has) begin
        due_results.push_back(r);
      end
    end

    write_garbage(8'hFF);
    send_random(280);

    write_garbage(8'h00);
    send_gap_pct = 64;
    recv_gap_pct <= 20;
    send_random(560);

    write_garbage(ByteW'($urandom_range(254, 1)));
    send_gap_pct = 0;
    recv_gap_pct <= 0;
    hold_requests <= hold_requests + 1;
    send_random(600);
    offer_frame(255);
    send_random(940);

    settle();
    if (fail_count == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

endmodule
